// ===== sv/radio_link_transaction_sequencer_defines.svh =====
// assertion macros for the radio link transaction sequencer
// included by the rtl files that carry concurrent checks; no other dependencies
`ifndef RADIO_LINK_TRANSACTION_SEQUENCER_DEFINES_SVH
`define RADIO_LINK_TRANSACTION_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RLTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rlts_pkg.sv =====
// shared types and codes for the radio link transaction sequencer
// no dependencies
`default_nettype none

package rlts_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_WAIT_TX = 3'd2,
        PH_WAIT_RX = 3'd3,
        PH_LISTEN  = 3'd4,
        PH_BACKOFF = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_LOAD   = 3'd1,
        CMD_TX     = 3'd2,
        CMD_TO_RX  = 3'd3,
        CMD_LISTEN = 3'd4,
        CMD_READ   = 3'd5,
        CMD_RXERR  = 3'd6,
        CMD_TO_TX  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        SRC_POS_X     = 3'd0,
        SRC_POS_Y     = 3'd1,
        SRC_ANGLE     = 3'd2,
        SRC_EXTRA     = 3'd3,
        SRC_FORWARD   = 3'd4,
        SRC_KEEPALIVE = 3'd5
    } t_src;

    // configuration register indexes
    localparam logic [2:0] CFG_SUBSCRIBED = 3'd0;
    localparam logic [2:0] CFG_SETTLE     = 3'd1;
    localparam logic [2:0] CFG_LISTEN     = 3'd2;
    localparam logic [2:0] CFG_BACKOFF    = 3'd3;
    localparam logic [2:0] CFG_KEEPALIVE  = 3'd4;

    localparam logic [7:0] SETTLE_RST    = 8'd10;
    localparam logic [7:0] LISTEN_RST    = 8'd30;
    localparam logic [7:0] BACKOFF_RST   = 8'd25;
    localparam logic [7:0] KEEPALIVE_RST = 8'd200;

    typedef struct packed {
        logic       subscribed;
        logic [7:0] settle;
        logic [7:0] listen;
        logic [7:0] backoff;
        logic [7:0] keepalive;
    } t_cfg;

    // one poll as seen by the sequencer, counter already advanced
    typedef struct packed {
        logic [7:0] ms;
        logic       irq;
        logic       tx_ok;
        logic       rx_ok;
        logic       reply;
    } t_poll;

    // sequencer results for the poll being accepted
    typedef struct packed {
        t_cmd   cmd;
        t_phase phase;
        logic   busy;
    } t_seq_stat;

endpackage

`default_nettype wire

// ===== sv/rlts_in_if.sv =====
// poll channel of the radio link transaction sequencer
// depends on nothing
`default_nettype none

interface rlts_in_if ();
    logic valid;
    logic ready;
    logic tick;
    logic forward_ready;
    logic radio_irq;
    logic tx_success;
    logic rx_success;
    logic expects_reply;

    modport source (output valid, tick, forward_ready, radio_irq, tx_success,
                    rx_success, expects_reply, input ready);
    modport sink   (input valid, tick, forward_ready, radio_irq, tx_success,
                    rx_success, expects_reply, output ready);
endinterface

`default_nettype wire

// ===== sv/rlts_out_if.sv =====
// result channel of the radio link transaction sequencer
// depends on rlts_pkg
`default_nettype none

interface rlts_out_if import rlts_pkg::*; ();
    logic   valid;
    logic   ready;
    t_cmd   command;
    t_src   message_source;
    logic   busy_res;
    t_phase phase;

    modport source (output valid, command, message_source, busy_res, phase, input ready);
    modport sink   (input valid, command, message_source, busy_res, phase, output ready);
endinterface

`default_nettype wire

// ===== sv/rlts_sched.sv =====
// message scheduler: forwarded commands, position query round-robin, keepalives
// depends on rlts_pkg
`default_nettype none

module rlts_sched import rlts_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_forward_ready,
    input  wire logic       i_busy,
    input  wire logic [7:0] i_ms,
    input  var  t_cfg       i_cfg,
    output logic            o_pick,
    output t_src            o_src
);

    logic       r_fwd_pend, n_fwd_pend;
    logic       r_last_fwd, n_last_fwd;
    logic [1:0] r_qidx,     n_qidx;
    t_src       r_src,      n_src;
    logic [7:0] r_ka_dl,    n_ka_dl;
    logic       fwd_now;

    always_comb begin
        fwd_now    = r_fwd_pend | i_forward_ready;
        n_fwd_pend = fwd_now;
        n_last_fwd = r_last_fwd;
        n_qidx     = r_qidx;
        n_src      = r_src;
        n_ka_dl    = r_ka_dl;
        o_pick     = 1'b0;
        if (!i_busy) begin
            if (fwd_now && !(i_cfg.subscribed && r_last_fwd)) begin
                // forwarded command, alternating with queries when subscribed
                n_src      = SRC_FORWARD;
                n_fwd_pend = 1'b0;
                n_last_fwd = 1'b1;
                o_pick     = 1'b1;
            end else if (i_cfg.subscribed) begin
                n_src      = t_src'({1'b0, r_qidx});
                n_qidx     = r_qidx + 2'd1;
                n_last_fwd = 1'b0;
                o_pick     = 1'b1;
            end else if (!fwd_now && i_ms == r_ka_dl) begin
                n_src   = SRC_KEEPALIVE;
                n_ka_dl = i_ms + i_cfg.keepalive;
                o_pick  = 1'b1;
            end
        end
    end

    assign o_src = n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_pend <= 1'b0;
            r_last_fwd <= 1'b0;
            r_qidx     <= 2'd0;
            r_src      <= SRC_POS_X;
            r_ka_dl    <= 8'd0;
        end else if (i_accept) begin
            r_fwd_pend <= n_fwd_pend;
            r_last_fwd <= n_last_fwd;
            r_qidx     <= n_qidx;
            r_src      <= n_src;
            r_ka_dl    <= n_ka_dl;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rlts_seq.sv =====
// transaction sequencer: load, settle, transmit, receive and back-off phases
// depends on rlts_pkg and the assertion macro header
`default_nettype none

`include "radio_link_transaction_sequencer_defines.svh"

module rlts_seq import rlts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  var  t_poll i_poll,
    input  var  t_cfg  i_cfg,
    input  wire logic i_pick,
    output logic      o_busy,
    output t_seq_stat o_stat
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_deadline, n_deadline;
    logic       r_busy, n_busy;
    logic       r_send, n_send;
    t_cmd       cmd;
    logic       due;
    logic       send_now;

    always_comb begin
        due        = (i_poll.ms == r_deadline);
        send_now   = r_send | i_pick;
        n_phase    = r_phase;
        n_deadline = r_deadline;
        n_busy     = r_busy;
        n_send     = send_now;
        cmd        = CMD_NONE;
        case (r_phase)
            PH_SETTLE: begin
                if (due) begin
                    cmd        = CMD_TX;
                    n_deadline = i_poll.ms + i_cfg.settle;
                    n_phase    = PH_WAIT_TX;
                end
            end
            PH_WAIT_TX: begin
                if (i_poll.irq || due) begin
                    if (i_poll.tx_ok) begin
                        if (i_poll.reply) begin
                            cmd        = CMD_TO_RX;
                            n_deadline = i_poll.ms + i_cfg.listen;
                            n_phase    = PH_WAIT_RX;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        // deadline kept from transmit
                        cmd     = CMD_TO_TX;
                        n_phase = PH_BACKOFF;
                    end
                end
            end
            PH_WAIT_RX: begin
                if (due) begin
                    cmd        = CMD_LISTEN;
                    n_deadline = i_poll.ms + i_cfg.listen;
                    n_phase    = PH_LISTEN;
                end
            end
            PH_LISTEN: begin
                if (i_poll.irq || due) begin
                    cmd        = i_poll.rx_ok ? CMD_READ : CMD_RXERR;
                    n_deadline = i_poll.ms + i_cfg.backoff;
                    n_phase    = PH_BACKOFF;
                end
            end
            PH_BACKOFF: begin
                if (due) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                if (send_now) begin
                    n_busy     = 1'b1;
                    cmd        = CMD_LOAD;
                    n_deadline = i_poll.ms + i_cfg.settle;
                    n_send     = 1'b0;
                    n_phase    = PH_SETTLE;
                end else begin
                    n_busy  = 1'b0;
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    assign o_busy       = r_busy;
    assign o_stat.cmd   = cmd;
    assign o_stat.phase = n_phase;
    assign o_stat.busy  = n_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_deadline <= 8'd0;
            r_busy     <= 1'b0;
            r_send     <= 1'b1;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_deadline <= n_deadline;
            r_busy     <= n_busy;
            r_send     <= n_send;
        end
    end

    `RLTS_ASSERT_NOW(a_busy_in_txn, i_clk, i_rst_n, r_phase != PH_IDLE, r_busy,
        "transaction in progress without busy flag")
    `RLTS_ASSERT_NEXT(a_load_starts, i_clk, i_rst_n,
        i_accept && r_phase == PH_IDLE && send_now,
        r_phase == PH_SETTLE && r_busy && !r_send,
        "pending send did not start a transaction")
    `RLTS_ASSERT_NEXT(a_hold_idle, i_clk, i_rst_n, !i_accept,
        $stable(r_phase) && $stable(r_deadline) && $stable(r_busy),
        "sequencer state moved without an accepted poll")

endmodule

`default_nettype wire

// ===== sv/radio_link_transaction_sequencer.sv =====
// top level of the radio link transaction sequencer
// depends on rlts_pkg, rlts_in_if, rlts_out_if, rlts_sched and rlts_seq
`default_nettype none

// Each accepted poll word is one poll of the link controller: the tick advances the
// 8-bit millisecond counter, forward_ready marks a forwarded command as pending, the
// scheduler picks the next message when no transaction is busy, and the sequencer takes
// one step. Every poll yields exactly one result word (command, message source, busy,
// phase). A poll is taken every clock cycle unless the output stalls; its result is registered and
// shows on the output in the next cycle. The single output register sets the rate: a new poll is accepted
// whenever that register is empty or its word is taken in the same cycle, so a stalled
// output stalls the input. Configuration writes go to i_cfg_idx 0..4 (subscription,
// settle, listen, back-off, keepalive period) and are meant to be made while idle.

module radio_link_transaction_sequencer import rlts_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    rlts_in_if.sink         i_req,
    rlts_out_if.source      o_res
);

    t_cfg      r_cfg;
    logic [7:0] r_ms;
    logic [7:0] ms_now;
    logic      accept;
    logic      pick;
    logic      busy;
    t_src      src;
    t_poll     poll;
    t_seq_stat stat;

    // output register
    logic      r_out_valid, n_out_valid;
    t_cmd      r_cmd;
    t_src      r_src;
    logic      r_busy_res;
    t_phase    r_phase_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.subscribed <= 1'b1;
            r_cfg.settle     <= SETTLE_RST;
            r_cfg.listen     <= LISTEN_RST;
            r_cfg.backoff    <= BACKOFF_RST;
            r_cfg.keepalive  <= KEEPALIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SUBSCRIBED: r_cfg.subscribed <= i_cfg_data[0];
                CFG_SETTLE:     r_cfg.settle     <= i_cfg_data;
                CFG_LISTEN:     r_cfg.listen     <= i_cfg_data;
                CFG_BACKOFF:    r_cfg.backoff    <= i_cfg_data;
                CFG_KEEPALIVE:  r_cfg.keepalive  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // take a poll when the output register is free or being drained
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    // counter advances before anything else in the poll
    assign ms_now = r_ms + {7'd0, i_req.tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= 8'd0;
        end else if (accept) begin
            r_ms <= ms_now;
        end
    end

    assign poll.ms    = ms_now;
    assign poll.irq   = i_req.radio_irq;
    assign poll.tx_ok = i_req.tx_success;
    assign poll.rx_ok = i_req.rx_success;
    assign poll.reply = i_req.expects_reply;

    rlts_sched u_sched (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_forward_ready (i_req.forward_ready),
        .i_busy          (busy),
        .i_ms            (ms_now),
        .i_cfg           (r_cfg),
        .o_pick          (pick),
        .o_src           (src)
    );

    rlts_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_poll   (poll),
        .i_cfg    (r_cfg),
        .i_pick   (pick),
        .o_busy   (busy),
        .o_stat   (stat)
    );

    // result word valid until the sink takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= stat.cmd;
            r_src       <= src;
            r_busy_res  <= stat.busy;
            r_phase_res <= stat.phase;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.command        = r_cmd;
    assign o_res.message_source = r_src;
    assign o_res.busy_res       = r_busy_res;
    assign o_res.phase          = r_phase_res;

endmodule

`default_nettype wire
